[hw/rtl/humidity_temperature_frame_decoder_unit_defines.svh]
// ----------------------------------------------------------------------------
// humidity_temperature_frame_decoder_unit assertion macros
// Concurrent check helpers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMPERATURE_FRAME_DECODER_UNIT_DEFINES_SVH
`define HUMIDITY_TEMPERATURE_FRAME_DECODER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define HTFD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("htfd check failed");

// next-cycle implication
`define HTFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("htfd check failed");

`else

`define HTFD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define HTFD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/htfd_pkg.sv]
// ----------------------------------------------------------------------------
// htfd_pkg
// Types and constants shared by the frame decoder modules, and the crc-8 step used by htfd_front.
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // scaling: raw * scale / full_scale, full scale is 2^16 - 1
  localparam int TEMP_PROD_W = 31;
  localparam int HUM_PROD_W  = 30;
  localparam logic [TEMP_PROD_W-1:0] TEMP_SCALE = 31'd17500;
  localparam logic [HUM_PROD_W-1:0]  HUM_SCALE  = 30'd10000;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  typedef enum logic [2:0] {
    POS_T_MSB = 3'd0,
    POS_T_LSB = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_MSB = 3'd3,
    POS_H_LSB = 3'd4,
    POS_H_CRC = 3'd5
  } pos_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } byte_item_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic               status;
  } result_item_t;

  // one complete frame handed from front to back
  typedef struct packed {
    logic [15:0] t_word;
    logic [15:0] h_word;
    logic        failed;
  } job_t;

  // msb-first crc-8, no final xor
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/humidity_temperature_frame_decoder_unit.sv]
// ----------------------------------------------------------------------------
// humidity_temperature_frame_decoder_unit
// Decodes six-byte sensor replies into checked, scaled temperature/humidity.
// ----------------------------------------------------------------------------
//   channel  | direction | payload        | role
//   byte_*   | in        | byte_item_t    | reply bytes, one per item
//   result_* | out       | result_item_t  | one item per complete frame
//
// one byte item per cycle is taken while the frame queue has room.
// a frame's result passes through the queue entry written when its sixth byte is
// accepted, then the multiply register, then the divide/offset register.
// reset clears position, crc, queue pointers and pipeline valids.
// result_stall freezes the back pipeline while a result is valid; bytes keep flowing until the queue fills.
`default_nettype none
`include "humidity_temperature_frame_decoder_unit_defines.svh"

module humidity_temperature_frame_decoder_unit #(
  parameter int QUEUE_DEPTH = htfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     byte_valid,
  output logic                    byte_stall,
  input  htfd_pkg::byte_item_t    byte_item,
  output logic                    result_valid,
  input  wire                     result_stall,
  output htfd_pkg::result_item_t  result_item
);
  import htfd_pkg::*;

  logic q_full, q_push, q_pop, q_head_valid;
  job_t push_job, head_job;

  htfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  htfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (head_job)
  );

  htfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (q_head_valid),
    .job          (head_job),
    .job_pop      (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  // a frame is never pushed into a full queue
  `HTFD_ASSERT_IMPL(a_no_push_full, clk, rst, q_push, !q_full)
  // a crc failure carries zero values
  `HTFD_ASSERT_IMPL(a_fail_zero, clk, rst, result_valid && result_item.status,
    result_item.temperature_centi == 15'sd0 && result_item.humidity_centi == 14'd0)
  // good results stay in the sensor's range
  `HTFD_ASSERT_IMPL(a_good_range, clk, rst, result_valid && !result_item.status,
    result_item.temperature_centi >= -15'sd4500 &&
    result_item.temperature_centi <= 15'sd13000 &&
    result_item.humidity_centi <= 14'd10000)
  // a popped frame leaves the queue with room for the next
  `HTFD_ASSERT_NEXT(a_pop_frees, clk, rst, q_pop && !q_push, !q_full)

endmodule

`default_nettype wire

[hw/rtl/htfd_front.sv]
// ----------------------------------------------------------------------------
// htfd_front
// Byte intake: tracks frame position, runs the crc, assembles the words.
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_front (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     byte_valid,
  output logic                    byte_stall,
  input  htfd_pkg::byte_item_t    byte_item,
  input  wire                     q_full,
  output logic                    q_push,
  output htfd_pkg::job_t          q_job
);
  import htfd_pkg::*;

  pos_t        pos, pos_next, pos_eff;
  logic [7:0]  crc, crc_next, crc_base;
  logic [15:0] t_word, t_word_next;
  logic [15:0] h_word, h_word_next;
  logic        failed, failed_next, fail_base, fail_chk;
  logic        restart, accept;

  assign byte_stall = q_full;
  assign accept     = byte_valid && !byte_stall;
  assign restart    = byte_item.frame_start || (pos > POS_H_CRC);
  assign pos_eff    = restart ? POS_T_MSB : pos;
  assign crc_base   = restart ? CRC_INIT : crc;
  assign fail_base  = restart ? 1'b0 : failed;

  // next position
  always_comb begin
    case (pos_eff)
      POS_T_MSB: pos_next = POS_T_LSB;
      POS_T_LSB: pos_next = POS_T_CRC;
      POS_T_CRC: pos_next = POS_H_MSB;
      POS_H_MSB: pos_next = POS_H_LSB;
      POS_H_LSB: pos_next = POS_H_CRC;
      POS_H_CRC: pos_next = POS_T_MSB;
      default:   pos_next = POS_T_MSB;
    endcase
  end

  // per-position data path
  always_comb begin
    crc_next    = crc_base;
    t_word_next = t_word;
    h_word_next = h_word;
    fail_chk    = fail_base;
    case (pos_eff)
      POS_T_MSB: begin
        crc_next    = crc_feed(crc_base, byte_item.rx_byte);
        t_word_next = {byte_item.rx_byte, t_word[7:0]};
      end
      POS_T_LSB: begin
        crc_next    = crc_feed(crc_base, byte_item.rx_byte);
        t_word_next = {t_word[15:8], byte_item.rx_byte};
      end
      POS_H_MSB: begin
        crc_next    = crc_feed(crc_base, byte_item.rx_byte);
        h_word_next = {byte_item.rx_byte, h_word[7:0]};
      end
      POS_H_LSB: begin
        crc_next    = crc_feed(crc_base, byte_item.rx_byte);
        h_word_next = {h_word[15:8], byte_item.rx_byte};
      end
      default: begin
        fail_chk = fail_base || (crc_base != byte_item.rx_byte);
        crc_next = CRC_INIT;
      end
    endcase
    // flag starts clean for the next frame
    failed_next = (pos_eff == POS_H_CRC) ? 1'b0 : fail_chk;
  end

  assign q_push       = accept && (pos_eff == POS_H_CRC);
  assign q_job.t_word = t_word;
  assign q_job.h_word = h_word;
  assign q_job.failed = fail_chk;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= POS_T_MSB;
      crc    <= CRC_INIT;
      failed <= 1'b0;
      t_word <= '0;
      h_word <= '0;
    end else if (accept) begin
      pos    <= pos_next;
      crc    <= crc_next;
      failed <= failed_next;
      t_word <= t_word_next;
      h_word <= h_word_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/htfd_queue.sv]
// ----------------------------------------------------------------------------
// htfd_queue
// Small register queue of finished frames between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_queue #(
  parameter int DEPTH = htfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  htfd_pkg::job_t    push_job,
  output logic              full,
  input  wire               pop,
  output logic              head_valid,
  output htfd_pkg::job_t    head_job
);
  import htfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/htfd_back.sv]
// ----------------------------------------------------------------------------
// htfd_back
// Scaling pipeline: constant multiply, then divide by 65535 and offset.
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_back (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     job_valid,
  input  htfd_pkg::job_t          job,
  output logic                    job_pop,
  output logic                    result_valid,
  input  wire                     result_stall,
  output htfd_pkg::result_item_t  result_item
);
  import htfd_pkg::*;

  logic                   advance;
  logic                   s1_valid;
  logic [TEMP_PROD_W-1:0] t_prod;
  logic [HUM_PROD_W-1:0]  h_prod;
  logic                   s1_failed;

  logic [14:0] t_q0, t_quot;
  logic [13:0] h_q0, h_quot;
  logic [16:0] t_rem, h_rem;
  logic [15:0] t_signed;
  result_item_t result_next;

  assign advance = !result_valid || !result_stall;
  assign job_pop = advance && job_valid;

  // x / 65535: x>>16 is short by at most one, remainder stays below 2*65535
  assign t_q0   = t_prod[TEMP_PROD_W-1:16];
  assign t_rem  = {1'b0, t_prod[15:0]} + 17'(t_q0);
  assign t_quot = t_q0 + 15'(t_rem >= FULL_SCALE);
  assign h_q0   = h_prod[HUM_PROD_W-1:16];
  assign h_rem  = {1'b0, h_prod[15:0]} + 17'(h_q0);
  assign h_quot = h_q0 + 14'(h_rem >= FULL_SCALE);

  assign t_signed = {1'b0, t_quot} - TEMP_OFFSET;

  always_comb begin
    if (s1_failed) begin
      result_next.temperature_centi = '0;
      result_next.humidity_centi    = '0;
      result_next.status            = 1'b1;
    end else begin
      result_next.temperature_centi = t_signed[14:0];
      result_next.humidity_centi    = h_quot;
      result_next.status            = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      t_prod      <= TEMP_PROD_W'(job.t_word) * TEMP_SCALE;
      h_prod      <= HUM_PROD_W'(job.h_word) * HUM_SCALE;
      s1_failed   <= job.failed;
      result_item <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= job_valid;
      result_valid <= s1_valid;
    end
  end

endmodule

`default_nettype wire
